// File: src/rbsi_pkg.sv
// Shared constants and types for the ray against axis-aligned box slab test.
package rbsi_pkg;

	// Width of every coordinate, distance and register word.
	localparam int unsigned COORD_W = 32;

	// Default number of fractional bits in the fixed-point format.
	localparam int unsigned FRAC_BITS_DEF = 16;

	// Number of axes handled in parallel.
	localparam int unsigned AXES = 3;

	// Configuration register indexes, taken from paddr[3:2].
	typedef enum logic [1:0] {
		REG_CENTER_X = 2'd0,
		REG_CENTER_Y = 2'd1,
		REG_CENTER_Z = 2'd2,
		REG_NONE     = 2'd3
	} reg_idx_t;

	// Per-item flags carried alongside the division pipeline.
	typedef struct packed {
		logic [AXES-1:0] par;   // axis direction is zero
		logic            miss;  // some parallel axis lies outside its slab
	} side_t;

	// Saturated signed limits of the coordinate word.
	localparam logic [COORD_W-1:0] Q_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] Q_MIN = {1'b1, {(COORD_W-1){1'b0}}};

endpackage

// File: src/ray_box_slab_intersect_top.sv
// Top level of the streaming ray against unit axis-aligned box slab test.
// One ray enters per cycle and one result leaves per cycle unless a result waits
// on m_tready. The path runs through two setup stages, the six pipelined dividers
// that produce one quotient bit per stage, one saturate-and-order stage and the
// output register; the default format is Q16.16. The whole pipeline advances
// whenever the output register is empty or being taken, so s_tready stays high
// except while a result waits on m_tready. The box center is written through the
// APB port; the user must write it only while the block is idle (not enforced).
module ray_box_slab_intersect_top #(
	parameter int unsigned FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// Input items.
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
	// Result items.
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,   // t_entry
	output logic [0:0]   m_tuser,   // hit
	// Configuration port.
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int unsigned CW   = rbsi_pkg::COORD_W;
	localparam int unsigned AX   = rbsi_pkg::AXES;
	localparam int unsigned PW   = CW + 1;            // center minus origin
	localparam int unsigned NUMW = CW + 2;            // p plus or minus one half
	localparam int unsigned NW   = NUMW + FRAC_BITS;  // scaled dividend magnitude
	localparam logic [PW-1:0]   HALF_P = PW'(1) << (FRAC_BITS - 1);
	localparam logic [NUMW-1:0] HALF_N = NUMW'(1) << (FRAC_BITS - 1);

	// Configuration registers.
	logic [CW-1:0]      center_q [AX];
	rbsi_pkg::reg_idx_t reg_idx;

	assign reg_idx = rbsi_pkg::reg_idx_t'(paddr[3:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q[0] <= '0;
			center_q[1] <= '0;
			center_q[2] <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				rbsi_pkg::REG_CENTER_X: center_q[0] <= pwdata;
				rbsi_pkg::REG_CENTER_Y: center_q[1] <= pwdata;
				rbsi_pkg::REG_CENTER_Z: center_q[2] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			rbsi_pkg::REG_CENTER_X: prdata = center_q[0];
			rbsi_pkg::REG_CENTER_Y: prdata = center_q[1];
			rbsi_pkg::REG_CENTER_Z: prdata = center_q[2];
			default:                prdata = '0;
		endcase
	end

	// The pipeline moves as a whole when the output register can take a result.
	logic ce;
	assign ce       = !m_tvalid || m_tready;
	assign s_tready = ce;

	// Stage 1: offset of the box center from the ray origin per axis.
	logic          v_s1;
	logic [PW-1:0] p_s1 [AX];
	logic [CW-1:0] d_s1 [AX];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ce) begin
			v_s1 <= s_tvalid;
		end
	end

	for (genvar a = 0; a < AX; a++) begin : g_s1
		logic [CW-1:0] org;
		assign org = s_tdata[a*CW +: CW];
		always_ff @(posedge clk) begin
			if (ce) begin
				p_s1[a] <= {center_q[a][CW-1], center_q[a]} - {org[CW-1], org};
				d_s1[a] <= s_tdata[(a+AX)*CW +: CW];
			end
		end
	end

	// Stage 2: slab numerators as magnitudes with result signs, parallel tests.
	logic            v_s2;
	rbsi_pkg::side_t side_s2;
	logic [NW-1:0]   na_s2 [AX];
	logic [NW-1:0]   nb_s2 [AX];
	logic [CW-1:0]   dm_s2 [AX];
	logic            sa_s2 [AX];
	logic            sb_s2 [AX];
	logic [AX-1:0]   par_c;
	logic [AX-1:0]   pmiss_c;

	for (genvar a = 0; a < AX; a++) begin : g_s2
		logic [NUMW-1:0] pa, pb;
		logic [NUMW-1:0] ma, mb;
		logic            dneg;

		assign pa   = {p_s1[a][PW-1], p_s1[a]} + HALF_N;
		assign pb   = {p_s1[a][PW-1], p_s1[a]} - HALF_N;
		assign ma   = pa[NUMW-1] ? (~pa + NUMW'(1)) : pa;
		assign mb   = pb[NUMW-1] ? (~pb + NUMW'(1)) : pb;
		assign dneg = d_s1[a][CW-1];

		// A zero direction misses when the offset lies beyond one half either way.
		assign par_c[a]   = (d_s1[a] == '0);
		assign pmiss_c[a] = par_c[a] &&
			(($signed(p_s1[a]) > $signed(HALF_P)) || ($signed(p_s1[a]) < -$signed(HALF_P)));

		always_ff @(posedge clk) begin
			if (ce) begin
				na_s2[a] <= {ma, {FRAC_BITS{1'b0}}};
				nb_s2[a] <= {mb, {FRAC_BITS{1'b0}}};
				dm_s2[a] <= dneg ? (~d_s1[a] + CW'(1)) : d_s1[a];
				sa_s2[a] <= pa[NUMW-1] ^ dneg;
				sb_s2[a] <= pb[NUMW-1] ^ dneg;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ce) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			side_s2.par  <= par_c;
			side_s2.miss <= |pmiss_c;
		end
	end

	// Division lanes: entry and exit distance for each axis.
	logic [NW-1:0] qa [AX];
	logic [NW-1:0] qb [AX];
	logic          qsa [AX];
	logic          qsb [AX];

	for (genvar a = 0; a < AX; a++) begin : g_div
		rbsi_div #(.NW(NW), .DW(CW)) u_div_a (
			.clk     (clk),
			.ce      (ce),
			.num     (na_s2[a]),
			.den     (dm_s2[a]),
			.neg_in  (sa_s2[a]),
			.quo     (qa[a]),
			.neg_out (qsa[a])
		);
		rbsi_div #(.NW(NW), .DW(CW)) u_div_b (
			.clk     (clk),
			.ce      (ce),
			.num     (nb_s2[a]),
			.den     (dm_s2[a]),
			.neg_in  (sb_s2[a]),
			.quo     (qb[a]),
			.neg_out (qsb[a])
		);
	end

	// Valid bits and per-item flags travel beside the dividers.
	logic            vd_s  [NW];
	rbsi_pkg::side_t sd_s  [NW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NW; i++) vd_s[i] <= 1'b0;
		end else if (ce) begin
			vd_s[0] <= v_s2;
			for (int i = 1; i < NW; i++) vd_s[i] <= vd_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			sd_s[0] <= side_s2;
			for (int i = 1; i < NW; i++) sd_s[i] <= sd_s[i-1];
		end
	end

	// Saturate a signed quotient given as magnitude and sign.
	function automatic logic [CW-1:0] sat_q(input logic [NW-1:0] q, input logic neg);
		logic over;
		logic [CW-1:0] r;
		if (neg) begin
			over = (|q[NW-1:CW]) || (q[CW-1] && (|q[CW-2:0]));
			r    = over ? rbsi_pkg::Q_MIN : (~q[CW-1:0] + CW'(1));
		end else begin
			over = |q[NW-1:CW-1];
			r    = over ? rbsi_pkg::Q_MAX : q[CW-1:0];
		end
		return r;
	endfunction

	// Stage 3: saturate, order the two crossings, drop parallel axes.
	logic          v_s3;
	logic          miss_s3;
	logic [CW-1:0] lo_s3 [AX];
	logic [CW-1:0] hi_s3 [AX];

	for (genvar a = 0; a < AX; a++) begin : g_s3
		logic [CW-1:0] ta, tb;
		logic          swap;
		assign ta   = sat_q(qa[a], qsa[a]);
		assign tb   = sat_q(qb[a], qsb[a]);
		assign swap = $signed(ta) > $signed(tb);
		always_ff @(posedge clk) begin
			if (ce) begin
				if (sd_s[NW-1].par[a]) begin
					lo_s3[a] <= rbsi_pkg::Q_MIN;
					hi_s3[a] <= rbsi_pkg::Q_MAX;
				end else begin
					lo_s3[a] <= swap ? tb : ta;
					hi_s3[a] <= swap ? ta : tb;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ce) begin
			v_s3 <= vd_s[NW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) miss_s3 <= sd_s[NW-1].miss;
	end

	// Output stage: narrow the interval over the three axes and decide.
	logic [CW-1:0] lo01, lo_all, hi01, hi_all;
	logic          hit_c;

	assign lo01   = ($signed(lo_s3[1]) > $signed(lo_s3[0])) ? lo_s3[1] : lo_s3[0];
	assign lo_all = ($signed(lo_s3[2]) > $signed(lo01)) ? lo_s3[2] : lo01;
	assign hi01   = ($signed(hi_s3[1]) < $signed(hi_s3[0])) ? hi_s3[1] : hi_s3[0];
	assign hi_all = ($signed(hi_s3[2]) < $signed(hi01)) ? hi_s3[2] : hi01;
	assign hit_c  = !miss_s3 && !($signed(lo_all) > $signed(hi_all));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (ce) begin
			m_tvalid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			m_tuser <= hit_c;
			m_tdata <= hit_c ? lo_all : '0;
		end
	end

endmodule

// File: src/rbsi_div.sv
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
module rbsi_div #(
	parameter int unsigned NW = 50,
	parameter int unsigned DW = 32
) (
	input  logic          clk,
	input  logic          ce,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic          neg_in,
	output logic [NW-1:0] quo,
	output logic          neg_out
);

	// Each stage holds the partial remainder, the divisor, the sign and a word that
	// shifts out dividend bits at the top and shifts in quotient bits at the bottom.
	logic [DW-1:0] rem_s [NW];
	logic [NW-1:0] nq_s  [NW];
	logic [DW-1:0] den_s [NW];
	logic          neg_s [NW];

	genvar k;
	generate
		for (k = 0; k < NW; k++) begin : g_stage
			logic [DW-1:0] rem_prev;
			logic [NW-1:0] nq_prev;
			logic [DW-1:0] den_prev;
			logic          neg_prev;
			logic [DW:0]   shifted;
			logic [DW:0]   diff;
			logic          ge;

			if (k == 0) begin : g_first
				assign rem_prev = '0;
				assign nq_prev  = num;
				assign den_prev = den;
				assign neg_prev = neg_in;
			end else begin : g_next
				assign rem_prev = rem_s[k-1];
				assign nq_prev  = nq_s[k-1];
				assign den_prev = den_s[k-1];
				assign neg_prev = neg_s[k-1];
			end

			// Bring down the next dividend bit and try the subtraction.
			assign shifted = {rem_prev, nq_prev[NW-1]};
			assign diff    = shifted - {1'b0, den_prev};
			assign ge      = !diff[DW];

			always_ff @(posedge clk) begin
				if (ce) begin
					rem_s[k] <= ge ? diff[DW-1:0] : shifted[DW-1:0];
					nq_s[k]  <= {nq_prev[NW-2:0], ge};
					den_s[k] <= den_prev;
					neg_s[k] <= neg_prev;
				end
			end
		end
	endgenerate

	assign quo     = nq_s[NW-1];
	assign neg_out = neg_s[NW-1];

endmodule

// File: src/rbsi_chk.sv
// Port-level checker for the slab test block, bound to the top level.
module rbsi_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        pready
);

	// A miss always reports a zero entry distance.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
		else $error("miss result with nonzero entry distance");

	// With the output register empty the block takes a new item.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output is empty");

	// A waiting result holds until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("result changed while stalled");

	// The configuration port never inserts wait states.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind ray_box_slab_intersect_top rbsi_chk u_rbsi_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.pready   (pready)
);

// File: tb/tb_ray_box_slab_intersect_top.sv
// Self-checking testbench for the streaming ray against unit box slab test.
module tb_ray_box_slab_intersect_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = rbsi_pkg::FRAC_BITS_DEF;
	localparam int LATENCY = FRAC + 38;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic signed [63:0] T_MAX = 64'sd2147483647;
	localparam logic signed [63:0] T_MIN = -64'sd2147483648;

	// One ray as it travels on the input bus.
	typedef struct packed {
		logic signed [31:0] dir_z;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_x;
		logic signed [31:0] org_z;
		logic signed [31:0] org_y;
		logic signed [31:0] org_x;
	} ray_t;

	// One result: hit flag and entry distance.
	typedef struct packed {
		logic               hit;
		logic signed [31:0] t_entry;
	} hit_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [191:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [31:0]  m_tdata;
	logic [0:0]   m_tuser;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [3:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	ray_box_slab_intersect_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	logic signed [31:0] box_center [3];
	ray_t pending_rays [$];
	hit_t expected_hits [$];
	int   error_count;
	int   idle_cycles;
	bit   sender_hold;
	int   burst_left;
	int   gap_left;
	int   stall_phase;
	int   stall_period;

	// Clock.
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Crossing distance of one slab plane, quotient saturated to the word range.
	function automatic logic signed [63:0] slab_quotient(logic signed [63:0] num,
			logic signed [63:0] dir);
		logic signed [63:0] q;
		q = (num <<< FRAC) / dir;
		if (q > T_MAX) q = T_MAX;
		if (q < T_MIN) q = T_MIN;
		return q;
	endfunction

	// Slab intersection of one ray with the unit box around box_center.
	function automatic hit_t intersect_ray(ray_t r);
		logic signed [63:0] half, p, ta, tb, tmp, lo, hi, d;
		logic signed [31:0] org [3];
		logic signed [31:0] dir [3];
		hit_t res;
		bit ok;
		half = 64'sd1 <<< (FRAC - 1);
		org = '{r.org_x, r.org_y, r.org_z};
		dir = '{r.dir_x, r.dir_y, r.dir_z};
		lo = T_MIN;
		hi = T_MAX;
		ok = 1'b1;
		for (int a = 0; a < 3; a++) begin
			p = 64'(box_center[a]) - 64'(org[a]);
			d = 64'(dir[a]);
			if (d == 0) begin
				if (p > half || p < -half) ok = 1'b0;
			end else begin
				ta = slab_quotient(p + half, d);
				tb = slab_quotient(p - half, d);
				if (ta > tb) begin
					tmp = ta;
					ta = tb;
					tb = tmp;
				end
				if (ta > lo) lo = ta;
				if (tb < hi) hi = tb;
			end
		end
		if (lo > hi) ok = 1'b0;
		res.hit = ok;
		res.t_entry = ok ? lo[31:0] : 32'sd0;
		return res;
	endfunction

	// Sender: bursts of items separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_hits.push_back(intersect_ray(ray_t'(s_tdata)));
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (pending_rays.size() > 0 && !sender_hold) begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_rays.pop_front();
					if (burst_left <= 0) begin
						burst_left <= $urandom_range(1, 40);
					end else if (burst_left == 1) begin
						burst_left <= 0;
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stalls on a pattern whose period changes now and then.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_phase <= 0;
			stall_period <= 1;
		end else begin
			stall_phase <= stall_phase + 1;
			if (stall_phase % 200 == 199) stall_period <= $urandom_range(1, 7);
			m_tready <= (stall_period == 1) ? 1'b1 : (stall_phase % stall_period != 0);
		end
	end

	// Checker of accepted results and watchdog.
	always @(posedge clk) begin
		hit_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_hits.size() == 0) begin
					$error("result with none expected: hit %0d t_entry %h", m_tuser, m_tdata);
					error_count++;
				end else begin
					want = expected_hits.pop_front();
					if (m_tuser[0] !== want.hit) begin
						$error("hit: expected %0d actual %0d", want.hit, m_tuser[0]);
						error_count++;
					end
					if (m_tdata !== want.t_entry) begin
						$error("t_entry: expected %h actual %h", want.t_entry, m_tdata);
						error_count++;
					end
				end
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("ray_box_slab_intersect_top test failed");
				$finish;
			end
		end
	end

	task automatic write_center(rbsi_pkg::reg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		box_center[idx] = value;
	endtask

	// Waits until every queued ray has gone in and every result has come out.
	task automatic drain_block();
		while (pending_rays.size() > 0 || s_tvalid || expected_hits.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [31:0] random_coord();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
			2: return 32'($signed($urandom_range(0, 1 << FRAC)) - (1 << (FRAC - 1)));
			3: return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($signed($urandom_range(0, 3 << FRAC)) - (3 << (FRAC - 1)));
		endcase
	endfunction

	function automatic logic [31:0] random_dir();
		case ($urandom_range(0, 6))
			0: return '0;
			1: return $urandom();
			2: return 32'($signed($urandom_range(0, 8)) - 4);
			3: return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($signed($urandom_range(0, 4 << FRAC)) - (2 << FRAC));
		endcase
	endfunction

	// Random rays with origins mostly near the box so many of them hit.
	task automatic queue_random_rays(int count);
		ray_t r;
		for (int n = 0; n < count; n++) begin
			r.org_x = box_center[0] + random_coord();
			r.org_y = box_center[1] + random_coord();
			r.org_z = box_center[2] + random_coord();
			if ($urandom_range(0, 9) == 0) begin
				r.org_x = $urandom();
				r.org_y = $urandom();
				r.org_z = $urandom();
			end
			r.dir_x = random_dir();
			r.dir_y = random_dir();
			r.dir_z = random_dir();
			pending_rays.push_back(r);
		end
	endtask

	initial begin
		ray_t r;
		logic [31:0] one;
		one = 32'(1) << FRAC;
		error_count = 0;
		idle_cycles = 0;
		sender_hold = 1'b0;
		box_center = '{0, 0, 0};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: parallel axes inside and outside, extremes and a plain hit.
		r = '{dir_z: 0, dir_y: 0, dir_x: 0, org_z: 0, org_y: 0, org_x: 0};
		pending_rays.push_back(r);
		r.org_x = one >> 1;
		pending_rays.push_back(r);
		r.org_x = (one >> 1) + 1;
		pending_rays.push_back(r);
		r.org_x = -(one >> 1) - 1;
		pending_rays.push_back(r);
		r = '{dir_z: 0, dir_y: 0, dir_x: one, org_z: 0, org_y: 0, org_x: -(3 * one)};
		pending_rays.push_back(r);
		r.dir_x = -one;
		pending_rays.push_back(r);
		r.dir_x = 1;
		pending_rays.push_back(r);
		r.dir_x = 32'h7fffffff;
		pending_rays.push_back(r);
		r.dir_x = 32'h80000000;
		pending_rays.push_back(r);
		r = '{dir_z: 32'h80000000, dir_y: 32'h7fffffff, dir_x: 32'hffffffff,
			org_z: 32'h80000000, org_y: 32'h7fffffff, org_x: 32'h80000000};
		pending_rays.push_back(r);
		r = '{dir_z: 32'hffffffff, dir_y: 32'hffffffff, dir_x: 32'hffffffff,
			org_z: 32'hffffffff, org_y: 32'hffffffff, org_x: 32'hffffffff};
		pending_rays.push_back(r);
		r = '{dir_z: one, dir_y: one, dir_x: one, org_z: -one, org_y: -one, org_x: -one};
		pending_rays.push_back(r);
		r.dir_y = 0;
		r.org_y = one;
		pending_rays.push_back(r);
		drain_block();

		// Random phases, each under its own box center, extremes included.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					write_center(rbsi_pkg::REG_CENTER_X, one);
					write_center(rbsi_pkg::REG_CENTER_Y, -one);
					write_center(rbsi_pkg::REG_CENTER_Z, one >> 2);
				end
				1: begin
					write_center(rbsi_pkg::REG_CENTER_X, 32'h7fffffff);
					write_center(rbsi_pkg::REG_CENTER_Y, 32'h80000000);
					write_center(rbsi_pkg::REG_CENTER_Z, 32'h7fffffff);
				end
				2: begin
					write_center(rbsi_pkg::REG_CENTER_X, 32'h80000000);
					write_center(rbsi_pkg::REG_CENTER_Y, 32'h7fffffff);
					write_center(rbsi_pkg::REG_CENTER_Z, 32'h80000000);
				end
				default: begin
					write_center(rbsi_pkg::REG_CENTER_X, $urandom());
					write_center(rbsi_pkg::REG_CENTER_Y,
						32'($signed($urandom_range(0, 64)) - 32) << FRAC);
					write_center(rbsi_pkg::REG_CENTER_Z, $urandom());
				end
			endcase
			queue_random_rays(100);
			// Hold the sender until the block has emptied once.
			while (pending_rays.size() > 0) @(posedge clk);
			sender_hold = 1'b1;
			while (s_tvalid || expected_hits.size() > 0) @(posedge clk);
			sender_hold = 1'b0;
			queue_random_rays(100);
			drain_block();
		end

		if (error_count == 0) begin
			$display("ray_box_slab_intersect_top test passed");
		end else begin
			$display("ray_box_slab_intersect_top test failed");
		end
		$finish;
	end

endmodule
